FILE: hw/rtl/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off while reset is low
`define CCV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked check that also holds during reset
`define CCV_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: hw/rtl/ccv_pkg.sv
// package: stage count, divider constants and calendar tables
package ccv_pkg;

  // pipeline depth
  localparam int unsigned NumStg = 11;

  // calendar constants
  localparam int unsigned YearsPerEra = 400;
  localparam int unsigned DaysPerEra  = 146097;
  localparam int unsigned DaysEraLast = 146096;
  localparam int unsigned DaysPerCent = 36524;
  localparam int unsigned DaysPer4Yr  = 1460;
  localparam int unsigned DaysPerYear = 365;
  localparam int unsigned DaysPer5Mon = 153;
  localparam int unsigned EpochShift  = 719468;

  // bias that makes the shifted year non-negative: 82 eras
  localparam int unsigned EraOffY  = 82;
  localparam int unsigned YearBias = EraOffY * YearsPerEra;
  // bias that makes the shifted day count non-negative: 53 eras
  localparam int unsigned EraOffD  = 53;
  localparam int unsigned DayBias  = EpochShift + EraOffD * DaysPerEra;

  // reciprocal multipliers, floor(2^sh / divisor), quotient low by at most one
  localparam int unsigned ShY       = 17;
  localparam int unsigned RecipY    = (1 << ShY) / YearsPerEra;
  localparam int unsigned ShEra     = 25;
  localparam int unsigned RecipEra  = (1 << ShEra) / DaysPerEra;
  localparam int unsigned ShDoe     = 18;
  localparam int unsigned Recip4Yr  = (1 << ShDoe) / DaysPer4Yr;
  localparam int unsigned RecipYear = (1 << ShDoe) / DaysPerYear;
  localparam int unsigned ShMon     = 11;
  localparam int unsigned RecipMon  = (1 << ShMon) / DaysPer5Mon;

  // first day of a march-based month, (153*mp+2)/5
  function automatic logic [8:0] mp_start(input logic [3:0] mp);
    logic [8:0] s;
    unique case (mp)
      4'd0:    s = 9'd0;
      4'd1:    s = 9'd31;
      4'd2:    s = 9'd61;
      4'd3:    s = 9'd92;
      4'd4:    s = 9'd122;
      4'd5:    s = 9'd153;
      4'd6:    s = 9'd184;
      4'd7:    s = 9'd214;
      4'd8:    s = 9'd245;
      4'd9:    s = 9'd275;
      4'd10:   s = 9'd306;
      4'd11:   s = 9'd337;
      4'd12:   s = 9'd367;
      default: s = 9'd0;
    endcase
    return s;
  endfunction

  // year of era divided by 100
  function automatic logic [1:0] cent_of(input logic [8:0] yoe);
    logic [1:0] c;
    priority if (yoe >= 9'd300) c = 2'd3;
    else if (yoe >= 9'd200)     c = 2'd2;
    else if (yoe >= 9'd100)     c = 2'd1;
    else                        c = 2'd0;
    return c;
  endfunction

endpackage

FILE: hw/rtl/ccv_days_from_date.sv
// date to day number datapath, five stages then a delay line
module ccv_days_from_date import ccv_pkg::*; (
  input  logic                    clk_i,
  input  logic [NumStg-1:0]       load_i,
  input  logic signed [15:0]      year_i,
  input  logic [3:0]              month_i,
  input  logic [4:0]              day_i,
  output logic signed [23:0]      day_number_o
);

  localparam int unsigned DnStg = 4;
  localparam int unsigned NumDly = NumStg - DnStg - 1;

  // start of month within the march-based year, months used as given
  function automatic logic [8:0] month_start(input logic [3:0] m);
    logic [3:0] mp;
    mp = (m > 4'd2) ? m - 4'd3 : m + 4'd9;
    return mp_start(mp);
  endfunction

  // stage 0: shift the year to march, bias it, day of year
  logic               jan_feb;
  logic signed [16:0] yp;
  logic [16:0]        u0_d, u0_q;
  logic signed [9:0]  doy0_d, doy0_q;

  always_comb begin
    jan_feb = (month_i <= 4'd2);
    yp      = 17'(year_i) - $signed({16'd0, jan_feb});
    u0_d    = 17'(yp) + 17'(YearBias);
    doy0_d  = $signed(10'(month_start(month_i)) + 10'(day_i) - 10'd1);
  end

  always_ff @(posedge clk_i) begin
    if (load_i[0]) begin
      u0_q   <= u0_d;
      doy0_q <= doy0_d;
    end
  end

  // stage 1: era estimate by reciprocal multiply
  logic [25:0]       prod1;
  logic [7:0]        qe1_q;
  logic [16:0]       u1_q;
  logic signed [9:0] doy1_q;

  assign prod1 = 26'(u0_q) * 26'(RecipY);

  always_ff @(posedge clk_i) begin
    if (load_i[1]) begin
      qe1_q  <= prod1[24:17];
      u1_q   <= u0_q;
      doy1_q <= doy0_q;
    end
  end

  // stage 2: correct the era, year of era
  logic [16:0]       rem2;
  logic              fix2;
  logic [7:0]        q2;
  logic signed [7:0] era2_q;
  logic [8:0]        yoe2_q;
  logic signed [9:0] doy2_q;

  always_comb begin
    rem2 = u1_q - 17'(qe1_q) * 17'(YearsPerEra);
    fix2 = (rem2 >= 17'(YearsPerEra));
    q2   = qe1_q + 8'(fix2);
  end

  always_ff @(posedge clk_i) begin
    if (load_i[2]) begin
      era2_q <= $signed(q2 - 8'(EraOffY));
      yoe2_q <= fix2 ? 9'(rem2 - 17'(YearsPerEra)) : rem2[8:0];
      doy2_q <= doy1_q;
    end
  end

  // stage 3: day of era and era offset
  logic [18:0]        base3;
  logic signed [18:0] doe3_q;
  logic signed [25:0] eday3_q;

  assign base3 = 19'(yoe2_q) * 19'(DaysPerYear) + 19'(yoe2_q >> 2)
               - 19'(cent_of(yoe2_q));

  always_ff @(posedge clk_i) begin
    if (load_i[3]) begin
      doe3_q  <= $signed(base3) + 19'(doy2_q);
      eday3_q <= 26'(era2_q) * $signed(26'(DaysPerEra));
    end
  end

  // stage 4: move to the 1970 epoch and saturate to 24 bits
  logic signed [26:0] sum4;
  logic signed [23:0] dn4_d, dn4_q;

  always_comb begin
    sum4 = 27'(eday3_q) + 27'(doe3_q) - $signed(27'(EpochShift));
    priority if (sum4 > $signed(27'(24'h7FFFFF))) dn4_d = 24'sh7FFFFF;
    else if (sum4 < -$signed(27'(24'h800000)))    dn4_d = 24'sh800000;
    else                                          dn4_d = sum4[23:0];
  end

  always_ff @(posedge clk_i) begin
    if (load_i[DnStg]) begin
      dn4_q <= dn4_d;
    end
  end

  // delay line up to the last stage
  logic signed [23:0] dly_q [NumDly];

  for (genvar i = 0; i < NumDly; i++) begin : g_dly
    always_ff @(posedge clk_i) begin
      if (load_i[DnStg + 1 + i]) begin
        dly_q[i] <= (i == 0) ? dn4_q : dly_q[(i == 0) ? 0 : i - 1];
      end
    end
  end

  assign day_number_o = dly_q[NumDly - 1];

endmodule

FILE: hw/rtl/ccv_date_from_days.sv
// day number to date datapath, eleven stages
module ccv_date_from_days import ccv_pkg::*; (
  input  logic               clk_i,
  input  logic [NumStg-1:0]  load_i,
  input  logic signed [23:0] day_number_i,
  output logic signed [15:0] year_o,
  output logic [3:0]         month_o,
  output logic [4:0]         day_o
);

  // stage 0: move to the march 0000 epoch and bias positive
  logic [25:0] u0_w;
  logic [24:0] u0_q;

  assign u0_w = 26'(day_number_i) + 26'(DayBias);

  always_ff @(posedge clk_i) begin
    if (load_i[0]) begin
      u0_q <= u0_w[24:0];
    end
  end

  // stage 1: era estimate
  logic [32:0] prod1;
  logic [6:0]  qe1_q;
  logic [24:0] u1_q;

  assign prod1 = 33'(u0_q) * 33'(RecipEra);

  always_ff @(posedge clk_i) begin
    if (load_i[1]) begin
      qe1_q <= prod1[31:25];
      u1_q  <= u0_q;
    end
  end

  // stage 2: correct the era, day of era
  logic [24:0]       diff2;
  logic [18:0]       rem2;
  logic              fix2;
  logic [6:0]        q2;
  logic signed [7:0] era2_q;
  logic [17:0]       doe2_q;

  always_comb begin
    diff2 = u1_q - 25'(qe1_q) * 25'(DaysPerEra);
    rem2  = diff2[18:0];
    fix2  = (rem2 >= 19'(DaysPerEra));
    q2    = qe1_q + 7'(fix2);
  end

  always_ff @(posedge clk_i) begin
    if (load_i[2]) begin
      era2_q <= $signed(8'(q2) - 8'(EraOffD));
      doe2_q <= fix2 ? 18'(rem2 - 19'(DaysPerEra)) : rem2[17:0];
    end
  end

  // stage 3: leap corrections, four-year count estimated
  logic [25:0]       prod3;
  logic [2:0]        cent3;
  logic [6:0]        ae3_q;
  logic [2:0]        cent3_q;
  logic              last3_q;
  logic [17:0]       doe3_q;
  logic signed [7:0] era3_q;

  always_comb begin
    prod3 = 26'(doe2_q) * 26'(Recip4Yr);
    priority if (doe2_q >= 18'(4 * DaysPerCent)) cent3 = 3'd4;
    else if (doe2_q >= 18'(3 * DaysPerCent))     cent3 = 3'd3;
    else if (doe2_q >= 18'(2 * DaysPerCent))     cent3 = 3'd2;
    else if (doe2_q >= 18'(DaysPerCent))         cent3 = 3'd1;
    else                                         cent3 = 3'd0;
  end

  always_ff @(posedge clk_i) begin
    if (load_i[3]) begin
      ae3_q   <= prod3[24:18];
      cent3_q <= cent3;
      last3_q <= (doe2_q == 18'(DaysEraLast));
      doe3_q  <= doe2_q;
      era3_q  <= era2_q;
    end
  end

  // stage 4: correct the four-year count, leap-free day count
  logic [17:0]       rem4;
  logic              fix4;
  logic [6:0]        a4;
  logic [17:0]       n4_q;
  logic [17:0]       doe4_q;
  logic signed [7:0] era4_q;

  always_comb begin
    rem4 = doe3_q - 18'(ae3_q) * 18'(DaysPer4Yr);
    fix4 = (rem4 >= 18'(DaysPer4Yr));
    a4   = ae3_q + 7'(fix4);
  end

  always_ff @(posedge clk_i) begin
    if (load_i[4]) begin
      n4_q   <= doe3_q - 18'(a4) + 18'(cent3_q) - 18'(last3_q);
      doe4_q <= doe3_q;
      era4_q <= era3_q;
    end
  end

  // stage 5: year of era estimate
  logic [27:0]       prod5;
  logic [8:0]        ye5_q;
  logic [17:0]       n5_q;
  logic [17:0]       doe5_q;
  logic signed [7:0] era5_q;

  assign prod5 = 28'(n4_q) * 28'(RecipYear);

  always_ff @(posedge clk_i) begin
    if (load_i[5]) begin
      ye5_q  <= prod5[26:18];
      n5_q   <= n4_q;
      doe5_q <= doe4_q;
      era5_q <= era4_q;
    end
  end

  // stage 6: correct the year of era
  logic [17:0]       rem6;
  logic              fix6;
  logic [8:0]        yoe6_q;
  logic [17:0]       doe6_q;
  logic signed [7:0] era6_q;

  always_comb begin
    rem6 = n5_q - 18'(ye5_q) * 18'(DaysPerYear);
    fix6 = (rem6 >= 18'(DaysPerYear));
  end

  always_ff @(posedge clk_i) begin
    if (load_i[6]) begin
      yoe6_q <= ye5_q + 9'(fix6);
      doe6_q <= doe5_q;
      era6_q <= era5_q;
    end
  end

  // stage 7: day of the march-based year
  logic [17:0]       base7;
  logic [17:0]       doyw7;
  logic [8:0]        doy7_q;
  logic [8:0]        yoe7_q;
  logic signed [7:0] era7_q;

  always_comb begin
    base7 = 18'(yoe6_q) * 18'(DaysPerYear) + 18'(yoe6_q >> 2) - 18'(cent_of(yoe6_q));
    doyw7 = doe6_q - base7;
  end

  always_ff @(posedge clk_i) begin
    if (load_i[7]) begin
      doy7_q <= doyw7[8:0];
      yoe7_q <= yoe6_q;
      era7_q <= era6_q;
    end
  end

  // stage 8: month estimate
  logic [10:0]       t8;
  logic [14:0]       prod8;
  logic [10:0]       t8_q;
  logic [3:0]        me8_q;
  logic [8:0]        doy8_q;
  logic [8:0]        yoe8_q;
  logic signed [7:0] era8_q;

  always_comb begin
    t8    = 11'(doy7_q) * 11'd5 + 11'd2;
    prod8 = 15'(t8) * 15'(RecipMon);
  end

  always_ff @(posedge clk_i) begin
    if (load_i[8]) begin
      t8_q   <= t8;
      me8_q  <= prod8[14:11];
      doy8_q <= doy7_q;
      yoe8_q <= yoe7_q;
      era8_q <= era7_q;
    end
  end

  // stage 9: correct the month
  logic [10:0]       rem9;
  logic              fix9;
  logic [3:0]        mp9_q;
  logic [8:0]        doy9_q;
  logic [8:0]        yoe9_q;
  logic signed [7:0] era9_q;

  always_comb begin
    rem9 = t8_q - 11'(me8_q) * 11'(DaysPer5Mon);
    fix9 = (rem9 >= 11'(DaysPer5Mon));
  end

  always_ff @(posedge clk_i) begin
    if (load_i[9]) begin
      mp9_q  <= me8_q + 4'(fix9);
      doy9_q <= doy8_q;
      yoe9_q <= yoe8_q;
      era9_q <= era8_q;
    end
  end

  // stage 10: day, civil month and year
  logic [8:0]         dayw10;
  logic [3:0]         mon10;
  logic signed [17:0] yr10;

  always_comb begin
    dayw10 = doy9_q - mp_start(mp9_q) + 9'd1;
    mon10  = (mp9_q < 4'd10) ? mp9_q + 4'd3 : mp9_q - 4'd9;
    yr10   = 18'(era9_q) * $signed(18'(YearsPerEra)) + $signed({9'd0, yoe9_q})
           + $signed({17'd0, (mon10 <= 4'd2)});
  end

  always_ff @(posedge clk_i) begin
    if (load_i[10]) begin
      day_o   <= dayw10[4:0];
      month_o <= mon10;
      year_o  <= yr10[15:0];
    end
  end

endmodule

FILE: hw/rtl/civil_date_day_number_convert.sv
// top level: civil date and day number converter with valid/stall pipeline
//
//   port group   dir   handshake                fields
//   in_*         in    in_valid_i, in_stall_o   kind, in_year, in_month, in_day, in_day_number
//   out_*        out   out_valid_o, out_stall_i out_day_number, out_year, out_month, out_day
//
// one word enters per cycle while in_stall_o is low, and its result leaves from the last stage
// both datapaths are eleven stages deep; the date-to-day-number one ends in a delay line
// reset clears the stage valid bits only; the datapath registers are not reset
// a stall holds only the stages that are full, bubbles close up behind it
`include "assert_macros.svh"

module civil_date_day_number_convert import ccv_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               kind_i,
  input  logic signed [15:0] in_year_i,
  input  logic [3:0]         in_month_i,
  input  logic [4:0]         in_day_i,
  input  logic signed [23:0] in_day_number_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [23:0] out_day_number_o,
  output logic signed [15:0] out_year_o,
  output logic [3:0]         out_month_o,
  output logic [4:0]         out_day_o
);

  logic [NumStg-1:0] valid_q, valid_d;
  logic [NumStg:0]   adv;
  logic              kind_q [NumStg];

  // a stage moves on when it is empty or the next one moves
  always_comb begin
    adv[NumStg] = !out_stall_i;
    for (int k = NumStg - 1; k >= 0; k--) begin
      adv[k] = !valid_q[k] || adv[k + 1];
    end
    for (int k = 0; k < NumStg; k++) begin
      if (adv[k]) begin
        valid_d[k] = (k == 0) ? in_valid_i : valid_q[(k == 0) ? 0 : k - 1];
      end else begin
        valid_d[k] = valid_q[k];
      end
    end
  end

  assign in_stall_o = !adv[0];

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // kind travels with the word
  for (genvar k = 0; k < NumStg; k++) begin : g_kind
    always_ff @(posedge clk_i) begin
      if (adv[k]) begin
        kind_q[k] <= (k == 0) ? kind_i : kind_q[(k == 0) ? 0 : k - 1];
      end
    end
  end

  // both datapaths run on every word
  logic signed [23:0] dn_w;
  logic signed [15:0] yr_w;
  logic [3:0]         mon_w;
  logic [4:0]         day_w;

  ccv_days_from_date u_to_days (
    .clk_i        (clk_i),
    .load_i       (adv[NumStg-1:0]),
    .year_i       (in_year_i),
    .month_i      (in_month_i),
    .day_i        (in_day_i),
    .day_number_o (dn_w)
  );

  ccv_date_from_days u_to_date (
    .clk_i        (clk_i),
    .load_i       (adv[NumStg-1:0]),
    .day_number_i (in_day_number_i),
    .year_o       (yr_w),
    .month_o      (mon_w),
    .day_o        (day_w)
  );

  // pick the result by kind, unused fields zero
  assign out_valid_o      = valid_q[NumStg-1];
  assign out_day_number_o = kind_q[NumStg-1] ? 24'sd0 : dn_w;
  assign out_year_o       = kind_q[NumStg-1] ? yr_w : 16'sd0;
  assign out_month_o      = kind_q[NumStg-1] ? mon_w : 4'd0;
  assign out_day_o        = kind_q[NumStg-1] ? day_w : 5'd0;

  // month of a converted date is in calendar range and its day is at least one
  logic date_ok;
  assign date_ok = (out_month_o >= 4'd1) && (out_month_o <= 4'd12) && (out_day_o >= 5'd1);

  // input is held back only when every stage is full
  `CCV_ASSERT_ALWAYS(a_stall_full, in_stall_o |-> (&valid_q), "stall with an empty stage")
  // a free first stage always takes a word
  `CCV_ASSERT(a_bubble_takes, !valid_q[0] |-> !in_stall_o, "bubble did not take input")
  // a converted date has a month in calendar range and a nonzero day
  `CCV_ASSERT(a_date_range, (out_valid_o && kind_q[NumStg-1]) |-> date_ok, "date out of range")

endmodule
